@@ rtl/birsz_pkg.sv @@
// shared constants and codes for the bilinear resize core
`default_nettype none

package birsz_pkg;

  // default sizes of the frame store and coefficient precision
  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;
  localparam int COEF_BITS_DEF  = 11;

  // fixed field widths
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 7;
  localparam int DIM_W       = 8;
  localparam int SCALE_W     = 23;
  localparam int CFG_INDEX_W = 2;

  // source position: (d+0.5)*scale - 0.5 pixel, in units of 2^-17
  localparam int POS_W         = 32;
  localparam int POS_FRAC_BITS = 17;
  localparam logic [POS_W-1:0] POS_OFFSET = 32'd65536;

  // register reset values
  localparam logic [DIM_W-1:0]   FRAME_COLS_RST = 8'd32;
  localparam logic [DIM_W-1:0]   FRAME_ROWS_RST = 8'd32;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 23'd65536;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_COLS = 2'd0,
    CFG_FRAME_ROWS = 2'd1,
    CFG_SCALE_X    = 2'd2,
    CFG_SCALE_Y    = 2'd3
  } cfg_index_t;

  // input commands
  typedef enum logic {
    CMD_STORE   = 1'b0,
    CMD_COMPUTE = 1'b1
  } command_t;

endpackage

`default_nettype wire

@@ rtl/birsz_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module birsz_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/bilinear_image_resize_fixed_point_core.sv @@
// bilinear resize core: frame store, position mapping, shared multiply sequencer
`default_nettype none

// Holds an 8-bit source frame in a single-port memory and returns bilinear
// interpolated destination pixels. A store transaction writes one pixel in
// the cycle it is accepted and the core is ready again in the next cycle;
// stores outside the frame memory are dropped. A compute transaction is
// accepted only while the core is idle and occupies it through the accept,
// the x and y position multiplies (the x split and clamp overlaps the y
// multiply), the y split and clamp, four reads of the frame memory, and the
// blend, all on one shared 19 by 23-bit multiplier with one accumulator.
// The result then waits in an output register, so the next transaction can
// be taken while it is still stalled; a second compute that finishes while
// that result is still stalled holds the core in its last state until the
// output register frees up. The frame memory is not cleared after reset: a
// compute that reads a pixel never stored returns an undefined value.
// Configuration must be written only while the core is idle; the core
// itself does not enforce this.
module bilinear_image_resize_fixed_point_core
  import birsz_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int COEF_BITS  = COEF_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]     cfg_data,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic                   command,
  input  logic [COORD_W-1:0]     col,
  input  logic [COORD_W-1:0]     row,
  input  logic [PIX_W-1:0]       pixel_in,
  // result channel
  output logic                   res_valid,
  input  logic                   res_stall,
  output logic [PIX_W-1:0]       pixel_out,
  output logic [COORD_W-1:0]     out_col,
  output logic [COORD_W-1:0]     out_row
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = COEF_BITS + 1;
  localparam int HW    = COEF_BITS + PIX_W;
  localparam int PW    = HW + SCALE_W;
  localparam int VW    = 2 * COEF_BITS + PIX_W + 1;
  localparam int SH    = POS_FRAC_BITS - COEF_BITS;
  localparam int CMP_W = 17;
  localparam int IP_W  = POS_W - POS_FRAC_BITS;

  localparam logic [CW-1:0]    COEF_ONE = CW'(1) << COEF_BITS;
  localparam logic [SH-1:0]    RND_HALF = {1'b1, {(SH-1){1'b0}}};
  localparam logic [VW-1:0]    V_ROUND  = VW'(1) << (2 * COEF_BITS - 1);
  localparam logic [VW-2*COEF_BITS-1:0] PIX_MAX = (VW-2*COEF_BITS)'(255);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULX,
    S_MULY,
    S_MAPY,
    S_RD00,
    S_RD01,
    S_RD10,
    S_RD11,
    S_H1A,
    S_H1B,
    S_V1,
    S_V2
  } state_t;

  state_t state;

  logic [DIM_W-1:0]   frame_cols;
  logic [DIM_W-1:0]   frame_rows;
  logic [SCALE_W-1:0] scale_x_q16;
  logic [SCALE_W-1:0] scale_y_q16;

  logic [COORD_W-1:0] req_col;
  logic [COORD_W-1:0] req_row;
  logic [XW-1:0]      x0;
  logic [XW-1:0]      x1;
  logic [YW-1:0]      y0;
  logic [YW-1:0]      y1;
  logic [CW-1:0]      a1;
  logic [CW-1:0]      b1;
  logic [PW-1:0]      prod;
  logic [VW-1:0]      acc;
  logic [HW-1:0]      hsave;

  // clamp a row index to 0..last
  function automatic logic [YW-1:0] clamp_row(input logic [CMP_W-1:0] r,
                                              input logic [CMP_W-1:0] last);
    logic [CMP_W-1:0] v;
    begin
      if (r[CMP_W-1]) begin
        v = '0;
      end else if (r > last) begin
        v = last;
      end else begin
        v = r;
      end
      return v[YW-1:0];
    end
  endfunction

  // effective frame size, last column and row
  logic [CMP_W-1:0] w_eff, h_eff, w_last, h_last;

  always_comb begin
    if (frame_cols == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(frame_cols) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(frame_cols);
    end
    if (frame_rows == '0) begin
      h_eff = CMP_W'(1);
    end else if (CMP_W'(frame_rows) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(frame_rows);
    end
    w_last = w_eff - CMP_W'(1);
    h_last = h_eff - CMP_W'(1);
  end

  // split the mapped position into integer part and rounded coefficient
  logic [POS_W-1:0]         pos;
  logic [CMP_W-1:0]         ip;
  logic [CMP_W-1:0]         ip_next_row;
  logic [POS_FRAC_BITS-1:0] frac;
  logic [COEF_BITS-1:0]     q;
  logic [SH-1:0]            rem;
  logic                     round_up;
  logic [CW-1:0]            coef;

  always_comb begin
    pos         = {1'b0, prod[POS_W-2:0]} - POS_OFFSET;
    ip          = {{(CMP_W-IP_W){pos[POS_W-1]}}, pos[POS_W-1:POS_FRAC_BITS]};
    ip_next_row = ip + CMP_W'(1);
    frac        = pos[POS_FRAC_BITS-1:0];
    q           = frac[POS_FRAC_BITS-1:SH];
    rem         = frac[SH-1:0];
    round_up    = (rem > RND_HALF) || ((rem == RND_HALF) && q[0]);
    coef        = CW'(q) + CW'(round_up);
  end

  // horizontal edge handling
  logic [CMP_W-1:0] sx;
  logic [CW-1:0]    ax;
  logic [XW-1:0]    x0_next, x1_next;
  logic [CW-1:0]    a1_next;

  always_comb begin
    if (ip[CMP_W-1]) begin
      sx = '0;
      ax = '0;
    end else begin
      sx = ip;
      ax = coef;
    end
    if (sx >= w_last) begin
      x0_next = w_last[XW-1:0];
      x1_next = w_last[XW-1:0];
      a1_next = '0;
    end else begin
      x0_next = sx[XW-1:0];
      x1_next = sx[XW-1:0] + XW'(1);
      a1_next = ax;
    end
  end

  // complementary coefficients
  logic [CW-1:0] a0, b0;
  assign a0 = COEF_ONE - a1;
  assign b0 = COEF_ONE - b1;

  // frame memory address: store address while idle, pixel reads otherwise
  logic [YW-1:0]      rd_r;
  logic [XW-1:0]      rd_c;
  logic [AW-1:0]      rd_addr, st_addr, mem_addr;
  logic               store_ok, mem_we;
  logic [PIX_W-1:0]   rdata;

  always_comb begin
    case (state)
      S_RD01: begin
        rd_r = y0;
        rd_c = x1;
      end
      S_RD10: begin
        rd_r = y1;
        rd_c = x0;
      end
      S_RD11: begin
        rd_r = y1;
        rd_c = x1;
      end
      default: begin
        rd_r = y0;
        rd_c = x0;
      end
    endcase
  end

  assign rd_addr   = AW'(rd_r) * AW'(MAX_WIDTH) + AW'(rd_c);
  assign st_addr   = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign store_ok  = (CMP_W'(col) < CMP_W'(MAX_WIDTH)) && (CMP_W'(row) < CMP_W'(MAX_HEIGHT));
  assign req_stall = (state != S_IDLE);
  assign mem_we    = req_valid && !req_stall && (command == CMD_STORE) && store_ok;
  assign mem_addr  = (state == S_IDLE) ? st_addr : rd_addr;

  birsz_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (pixel_in),
    .rdata (rdata)
  );

  // shared multiplier operand select
  logic [HW-1:0]      mul_a;
  logic [SCALE_W-1:0] mul_b;
  logic [PW-1:0]      mul_out;
  logic               mul_en;

  always_comb begin
    mul_en = 1'b1;
    case (state)
      S_MULX: begin
        mul_a = HW'({req_col, 1'b1});
        mul_b = scale_x_q16;
      end
      S_MULY: begin
        mul_a = HW'({req_row, 1'b1});
        mul_b = scale_y_q16;
      end
      S_RD01: begin
        mul_a = HW'(rdata);
        mul_b = SCALE_W'(a0);
      end
      S_RD10: begin
        mul_a = HW'(rdata);
        mul_b = SCALE_W'(a1);
      end
      S_RD11: begin
        mul_a = HW'(rdata);
        mul_b = SCALE_W'(a0);
      end
      S_H1A: begin
        mul_a = HW'(rdata);
        mul_b = SCALE_W'(a1);
      end
      S_H1B: begin
        mul_a = hsave;
        mul_b = SCALE_W'(b0);
      end
      S_V1: begin
        mul_a = acc[HW-1:0];
        mul_b = SCALE_W'(b1);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_out = PW'(mul_a) * PW'(mul_b);

  // final vertical sum, round, shift and saturate
  logic [VW-1:0]               vsum;
  logic [VW-2*COEF_BITS-1:0]   vshift;
  logic [PIX_W-1:0]            pix_res;

  always_comb begin
    vsum    = acc + prod[VW-1:0] + V_ROUND;
    vshift  = vsum[VW-1:2*COEF_BITS];
    pix_res = (vshift > PIX_MAX) ? PIX_MAX[PIX_W-1:0] : vshift[PIX_W-1:0];
  end

  // result register loads once it is empty or being taken
  logic res_load;
  assign res_load = (state == S_V2) && (!res_valid || !res_stall);

  // sequencer, datapath registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      frame_cols  <= FRAME_COLS_RST;
      frame_rows  <= FRAME_ROWS_RST;
      scale_x_q16 <= SCALE_RST;
      scale_y_q16 <= SCALE_RST;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_COLS: frame_cols  <= cfg_data[DIM_W-1:0];
          CFG_FRAME_ROWS: frame_rows  <= cfg_data[DIM_W-1:0];
          CFG_SCALE_X:    scale_x_q16 <= cfg_data;
          CFG_SCALE_Y:    scale_y_q16 <= cfg_data;
          default: ;
        endcase
      end

      // result transaction loaded or taken
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      if (mul_en) begin
        prod <= mul_out;
      end

      case (state)
        S_IDLE: begin
          if (req_valid && (command == CMD_COMPUTE)) begin
            req_col <= col;
            req_row <= row;
            state   <= S_MULX;
          end
        end
        S_MULX: state <= S_MULY;
        S_MULY: begin
          // prod holds the x position
          x0    <= x0_next;
          x1    <= x1_next;
          a1    <= a1_next;
          state <= S_MAPY;
        end
        S_MAPY: begin
          // prod holds the y position
          y0    <= clamp_row(ip, h_last);
          y1    <= clamp_row(ip_next_row, h_last);
          b1    <= coef;
          state <= S_RD00;
        end
        S_RD00: state <= S_RD01;
        S_RD01: state <= S_RD10;
        S_RD10: begin
          acc   <= prod[VW-1:0];
          state <= S_RD11;
        end
        S_RD11: begin
          acc   <= acc + prod[VW-1:0];
          state <= S_H1A;
        end
        S_H1A: begin
          hsave <= acc[HW-1:0];
          acc   <= prod[VW-1:0];
          state <= S_H1B;
        end
        S_H1B: begin
          acc   <= acc + prod[VW-1:0];
          state <= S_V1;
        end
        S_V1: begin
          acc   <= prod[VW-1:0];
          state <= S_V2;
        end
        S_V2: begin
          // hold until the result register is free
          if (res_load) begin
            pixel_out <= pix_res;
            out_col   <= req_col;
            out_row   <= req_row;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
